[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PRCA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PRCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/prca_pkg.sv]
// Package with constants, register indexes and the arctangent table.
package prca_pkg;

  localparam int PRCA_MAX_POINTS = 1048576;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_CNT_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd2;

  localparam logic [14:0] RST_MAX_RANGE = 15'd3000;
  localparam logic signed [15:0] RST_BAND_LOW  = -16'sd100;
  localparam logic signed [15:0] RST_BAND_HIGH = 16'sd100;

  localparam int CORDIC_STEPS = 20;
  localparam int HALF_TURN = 4608000;

  // atan(2^-i) in 1/256 of a hundredth degree.
  function automatic logic [20:0] atan_val(input logic [4:0] i);
    logic [20:0] v;
    case (i)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/prca_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module prca_div import prca_pkg::*; #(
  parameter int W = 37
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    shifted;
  logic          ge;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? W'(shifted - {1'b0, dvs_r}) : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

[rtl/prca_cordic.sv]
// Iterative CORDIC vectoring unit for the azimuth of the mean point.
module prca_cordic import prca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] mx,
  input  logic signed [15:0] mz,
  output logic               done,
  output logic signed [15:0] az
);
  localparam int XY_W = 33;
  localparam int ACC_W = 25;

  logic signed [XY_W-1:0]  x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, tab;
  logic [4:0]              step_r, step_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;
  logic                    negx_r, negz_r, zero_r;
  logic [16:0]             ax, azm;
  logic signed [ACC_W:0]   m, mc;
  logic [22:0]             rnd;
  logic signed [15:0]      az_r, az_nxt;

  always_comb begin
    ax  = mx[15] ? 17'(-$signed({mx[15], mx})) : {1'b0, mx};
    azm = mz[15] ? 17'(-$signed({mz[15], mz})) : {1'b0, mz};
    dx  = y_r >>> step_r;
    dy  = x_r >>> step_r;
    tab = $signed({4'b0, atan_val(step_r)});
    m   = negz_r ? (ACC_W+1)'(HALF_TURN) - (ACC_W+1)'(acc_r) : (ACC_W+1)'(acc_r);
    if (m < 0) mc = '0;
    else if (m > (ACC_W+1)'(HALF_TURN)) mc = (ACC_W+1)'(HALF_TURN);
    else mc = m;
    rnd = 23'(mc + (ACC_W+1)'(128));
    az_nxt = az_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = XY_W'({azm, 14'b0});
      y_nxt    = XY_W'({ax, 14'b0});
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (step_r == 5'(CORDIC_STEPS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (zero_r) az_nxt = '0;
        else az_nxt = negx_r ? -$signed({1'b0, rnd[22:8]}) : $signed({1'b0, rnd[22:8]});
      end else begin
        if (y_r > 0) begin
          x_nxt   = x_r + dx;
          y_nxt   = y_r - dy;
          acc_nxt = acc_r + tab;
        end else begin
          x_nxt   = x_r - dx;
          y_nxt   = y_r + dy;
          acc_nxt = acc_r - tab;
        end
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    az_r  <= az_nxt;
    if (start) begin
      negx_r <= mx[15];
      negz_r <= mz[15];
      zero_r <= (mx == 16'sd0) && (mz == 16'sd0);
    end
  end

  assign done = done_r;
  assign az   = az_r;
endmodule

[rtl/point_roi_centroid_azimuth_core.sv]
// Top level: point filter and accumulator with frame-end divide and arctangent.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | pos_x, pos_y, pos_z, frame_end
//  out     | output    | out_valid/out_stall| point_count, found, mean_x, mean_z, azimuth
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// For each point one multiplier squares x, then z, then max_range in turn.
// A frame end with points runs two divisions in turn on one restoring divider, then the
// CORDIC unit, and then loads the output register; an empty frame loads it directly.
// Reset is synchronous and clears sums, count, state and configuration to defaults.
// A held result in the output register stalls the block only at the next frame end.
module point_roi_centroid_azimuth_core import prca_pkg::*; #(
  parameter int MAX_POINTS = PRCA_MAX_POINTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_pos_x,
  input  logic signed [15:0]      in_pos_y,
  input  logic signed [15:0]      in_pos_z,
  input  logic                    in_frame_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_CNT_W-1:0]    out_point_count,
  output logic                    out_found,
  output logic signed [15:0]      out_mean_x,
  output logic signed [15:0]      out_mean_z,
  output logic signed [15:0]      out_azimuth,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 16 + CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MZ   = 4'd2;
  localparam logic [3:0] S_MR   = 4'd3;
  localparam logic [3:0] S_DX0  = 4'd4;
  localparam logic [3:0] S_DX1  = 4'd5;
  localparam logic [3:0] S_DZ0  = 4'd6;
  localparam logic [3:0] S_DZ1  = 4'd7;
  localparam logic [3:0] S_CR0  = 4'd8;
  localparam logic [3:0] S_CR1  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [14:0]             max_range_r;
  logic signed [15:0]      band_low_r, band_high_r;
  logic signed [15:0]      px_r, py_r, pz_r;
  logic                    last_r;
  logic [31:0]             d2_r, d2_nxt;
  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_z_r, sum_z_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [15:0]      mul_a;
  logic signed [31:0]      prod;
  logic                    hit;
  logic signed [15:0]      mx_r, mx_nxt, mz_r, mz_nxt;
  logic                    div_start, div_done, cor_start, cor_done;
  logic signed [SUM_W-1:0] div_src;
  logic [SUM_W-1:0]        div_dvd, div_q;
  logic signed [15:0]      div_mean, cor_az;
  logic                    load_out;
  logic                    out_valid_r;
  logic [OUT_CNT_W-1:0]    ocnt_r;
  logic                    ofound_r;
  logic signed [15:0]      omx_r, omz_r, oaz_r;

  always_comb begin
    case (state_r)
      S_MX:    mul_a = px_r;
      S_MZ:    mul_a = pz_r;
      default: mul_a = $signed({1'b0, max_range_r});
    endcase
    prod = mul_a * mul_a;
    hit  = (pz_r != 16'sd0) && (py_r >= band_low_r) && (py_r < band_high_r) &&
           (d2_r < $unsigned(prod)) && (cnt_r < CNT_W'(MAX_POINTS));
  end

  // The divider sees magnitudes; the quotient takes the sign of the sum.
  assign div_src  = (state_r == S_DX0 || state_r == S_DX1) ? sum_x_r : sum_z_r;
  assign div_dvd  = div_src[SUM_W-1] ? SUM_W'(-div_src) : $unsigned(div_src);
  assign div_mean = div_src[SUM_W-1] ? -$signed(div_q[15:0]) : $signed(div_q[15:0]);
  assign div_start = (state_r == S_DX0) || (state_r == S_DZ0);
  assign cor_start = (state_r == S_CR0);
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    d2_nxt    = d2_r;
    sum_x_nxt = sum_x_r;
    sum_z_nxt = sum_z_r;
    cnt_nxt   = cnt_r;
    mx_nxt    = mx_r;
    mz_nxt    = mz_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MX;
      S_MX: begin
        d2_nxt    = $unsigned(prod);
        state_nxt = S_MZ;
      end
      S_MZ: begin
        d2_nxt    = d2_r + $unsigned(prod);
        state_nxt = S_MR;
      end
      S_MR: begin
        if (hit) begin
          sum_x_nxt = sum_x_r + SUM_W'(px_r);
          sum_z_nxt = sum_z_r + SUM_W'(pz_r);
          cnt_nxt   = cnt_r + 1'b1;
        end
        if (last_r) begin
          mx_nxt = '0;
          mz_nxt = '0;
          if ((cnt_r != '0) || hit) state_nxt = S_DX0;
          else state_nxt = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DX0: state_nxt = S_DX1;
      S_DX1: if (div_done) begin
        mx_nxt    = div_mean;
        state_nxt = S_DZ0;
      end
      S_DZ0: state_nxt = S_DZ1;
      S_DZ1: if (div_done) begin
        mz_nxt    = div_mean;
        state_nxt = S_CR0;
      end
      S_CR0: state_nxt = S_CR1;
      S_CR1: if (cor_done) state_nxt = S_FIN;
      S_FIN: if (load_out) begin
        sum_x_nxt = '0;
        sum_z_nxt = '0;
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_x_r     <= '0;
      sum_z_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      max_range_r <= RST_MAX_RANGE;
      band_low_r  <= RST_BAND_LOW;
      band_high_r <= RST_BAND_HIGH;
    end else begin
      state_r <= state_nxt;
      sum_x_r <= sum_x_nxt;
      sum_z_r <= sum_z_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_RANGE: max_range_r <= cfg_wdata[14:0];
          REG_BAND_LOW:  band_low_r  <= $signed(cfg_wdata);
          REG_BAND_HIGH: band_high_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
    end
    d2_r <= d2_nxt;
    mx_r <= mx_nxt;
    mz_r <= mz_nxt;
    if (state_r == S_IDLE && in_valid) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pz_r   <= in_pos_z;
      last_r <= in_frame_end;
    end
    if (load_out) begin
      ocnt_r   <= OUT_CNT_W'(cnt_r);
      ofound_r <= cnt_r != '0;
      omx_r    <= mx_r;
      omz_r    <= mz_r;
      oaz_r    <= (cnt_r != '0) ? cor_az : 16'sd0;
    end
  end

  prca_div #(.W(SUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (SUM_W'(cnt_r)),
    .done     (div_done),
    .quotient (div_q)
  );

  prca_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .mx    (mx_r),
    .mz    (mz_r),
    .done  (cor_done),
    .az    (cor_az)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_count = ocnt_r;
  assign out_found       = ofound_r;
  assign out_mean_x      = omx_r;
  assign out_mean_z      = omz_r;
  assign out_azimuth     = oaz_r;
endmodule

[rtl/prca_checker.sv]
// Port-level checker for the centroid and azimuth block, with its bind.
`include "assert_macros.svh"
module prca_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [20:0]        out_point_count,
  input logic               out_found,
  input logic signed [15:0] out_mean_x,
  input logic signed [15:0] out_mean_z,
  input logic signed [15:0] out_azimuth
);
  // Each point request keeps the block busy for the filter steps.
  `PRCA_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
  `PRCA_ASSERT_NOW(a_found_count, clk, rst_n, out_valid, out_found == (out_point_count != 21'd0))
  `PRCA_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !out_found, (out_mean_x == 16'sd0) && (out_mean_z == 16'sd0) && (out_azimuth == 16'sd0))
  `PRCA_ASSERT_NOW(a_az_range, clk, rst_n, out_valid, (out_azimuth >= -16'sd18000) && (out_azimuth <= 16'sd18000))
  `PRCA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

bind point_roi_centroid_azimuth_core prca_checker u_prca_checker (.*);
